[design/delayed_reject_gate_scheduler_defines.svh]
// Assertion macros used by the checker file drgs_checker.sv.
`ifndef DELAYED_REJECT_GATE_SCHEDULER_DEFINES_SVH
`define DELAYED_REJECT_GATE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DRGS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DRGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/drgs_pkg.sv]
`default_nettype none

package drgs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ENCODER_MAX = 65535;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
	localparam logic [32:0] ENC_MAX_X = 33'(ENCODER_MAX);

	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic MODE_ENCODER = 1'b0;
	localparam logic MODE_MS = 1'b1;

	typedef struct packed {
		logic        func;
		logic        mode;
		logic [31:0] start_mark;
		logic [15:0] delay;
		logic [15:0] pulse_width;
		logic [15:0] encoder_now;
		logic [31:0] time_now_ms;
	} in_item_t;

	typedef struct packed {
		logic gate_on;
		logic fired;
		logic released;
		logic dropped;
	} out_item_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] start;
		logic [15:0] delay;
		logic [15:0] width;
	} pend_entry_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] start;
		logic [15:0] width;
	} fire_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic        gate;
		logic        mark_we;
		logic [31:0] mark;
	} sched_upd_t;

	// neg takes the carry bit of the wrapped encoder distance sum
	typedef struct packed {
		logic        neg;
		logic [31:0] span;
	} elapsed_t;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_tail(logic [PTR_W-1:0] head,
		logic [CNT_W-1:0] count);
		logic [SUM_W-1:0] s;
		s = SUM_W'(head) + SUM_W'(count);
		if (s >= SUM_DEPTH)
			s = s - SUM_DEPTH;
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Distance on a down-counting wrapping encoder, or plain ms difference
	function automatic elapsed_t elapsed(logic mode, logic [31:0] mark,
		logic [15:0] enc, logic [31:0] ms);
		elapsed_t r;
		logic [32:0] enc_x;
		logic [32:0] mark_x;
		logic [32:0] sum;
		enc_x = 33'(enc);
		mark_x = {1'b0, mark};
		sum = mark_x + ENC_MAX_X - enc_x;
		if (mode == MODE_MS) begin
			r.neg = 1'b0;
			r.span = abs_diff(ms, mark);
		end else if (enc_x <= mark_x) begin
			r.neg = 1'b0;
			r.span = mark - 32'(enc);
		end else begin
			r.neg = sum[32];
			r.span = sum[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/drgs_if.sv]
`default_nettype none

interface drgs_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        mode;
	logic [31:0] start_mark;
	logic [15:0] delay;
	logic [15:0] pulse_width;
	logic [15:0] encoder_now;
	logic [31:0] time_now_ms;

	modport source (output valid, func, mode, start_mark, delay, pulse_width,
		encoder_now, time_now_ms, input ready);
	modport sink (input valid, func, mode, start_mark, delay, pulse_width,
		encoder_now, time_now_ms, output ready);
endinterface

interface drgs_out_if;
	logic valid;
	logic ready;
	logic gate_on;
	logic fired;
	logic released;
	logic dropped;

	modport source (output valid, gate_on, fired, released, dropped, input ready);
	modport sink (input valid, gate_on, fired, released, dropped, output ready);
endinterface

`default_nettype wire

[design/drgs_pend_queue.sv]
`default_nettype none

module drgs_pend_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  drgs_pkg::q_ctl_t    ctl,
	input  drgs_pkg::pend_entry_t push_entry,
	output drgs_pkg::pend_entry_t head_entry,
	output logic                empty,
	output logic                full
);

	drgs_pkg::pend_entry_t mem_q [drgs_pkg::QUEUE_DEPTH];
	drgs_pkg::pend_entry_t head_rd_q;
	logic [drgs_pkg::PTR_W-1:0] head_q;
	logic [drgs_pkg::CNT_W-1:0] count_q;
	logic [drgs_pkg::PTR_W-1:0] tail;
	logic [drgs_pkg::PTR_W-1:0] head_nxt;

	assign tail = drgs_pkg::ptr_tail(head_q, count_q);
	assign head_nxt = ctl.pop ? drgs_pkg::ptr_next(head_q) : head_q;
	assign head_entry = head_rd_q;
	assign empty = (count_q == '0);
	assign full = (count_q == drgs_pkg::CNT_FULL);

	// write the new request at the tail and register the next head entry,
	// taking the new request directly when it becomes the head
	always_ff @(posedge clk) begin
		if (ctl.push)
			mem_q[tail] <= push_entry;
		if (ctl.push && (tail == head_nxt))
			head_rd_q <= push_entry;
		else
			head_rd_q <= mem_q[head_nxt];
	end

	// advance head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop)
				head_q <= drgs_pkg::ptr_next(head_q);
			case ({ctl.push, ctl.pop})
				2'b10: count_q <= count_q + drgs_pkg::CNT_W'(1);
				2'b01: count_q <= count_q - drgs_pkg::CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/drgs_fire_queue.sv]
`default_nettype none

module drgs_fire_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  drgs_pkg::q_ctl_t      ctl,
	input  drgs_pkg::fire_entry_t push_entry,
	output drgs_pkg::fire_entry_t head_entry,
	output logic                  empty,
	output logic                  full
);

	drgs_pkg::fire_entry_t mem_q [drgs_pkg::QUEUE_DEPTH];
	drgs_pkg::fire_entry_t head_rd_q;
	logic [drgs_pkg::PTR_W-1:0] head_q;
	logic [drgs_pkg::CNT_W-1:0] count_q;
	logic [drgs_pkg::PTR_W-1:0] tail;
	logic [drgs_pkg::PTR_W-1:0] head_nxt;

	// head+count is the tail before and after a pop in the same cycle
	assign tail = drgs_pkg::ptr_tail(head_q, count_q);
	assign head_nxt = ctl.pop ? drgs_pkg::ptr_next(head_q) : head_q;
	assign head_entry = head_rd_q;
	assign empty = (count_q == '0);
	assign full = (count_q == drgs_pkg::CNT_FULL);

	// write the fired entry at the tail and register the next head entry,
	// taking the new entry directly when it becomes the head
	always_ff @(posedge clk) begin
		if (ctl.push)
			mem_q[tail] <= push_entry;
		if (ctl.push && (tail == head_nxt))
			head_rd_q <= push_entry;
		else
			head_rd_q <= mem_q[head_nxt];
	end

	// advance head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop)
				head_q <= drgs_pkg::ptr_next(head_q);
			case ({ctl.push, ctl.pop})
				2'b10: count_q <= count_q + drgs_pkg::CNT_W'(1);
				2'b01: count_q <= count_q - drgs_pkg::CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/drgs_decide.sv]
`default_nettype none

module drgs_decide (
	input  drgs_pkg::in_item_t    item,
	input  drgs_pkg::pend_entry_t pend_head,
	input  logic                  pend_empty,
	input  logic                  pend_full,
	input  drgs_pkg::fire_entry_t fire_head,
	input  logic                  fire_empty,
	input  logic                  fire_full,
	input  logic [31:0]           last_mark,
	input  logic                  gate,
	output drgs_pkg::q_ctl_t      pend_ctl,
	output drgs_pkg::q_ctl_t      fire_ctl,
	output drgs_pkg::pend_entry_t pend_push,
	output drgs_pkg::fire_entry_t fire_push,
	output drgs_pkg::sched_upd_t  upd,
	output drgs_pkg::out_item_t   result
);

	drgs_pkg::elapsed_t fire_el;
	drgs_pkg::elapsed_t pend_el;
	logic        fire_done;
	logic        hold;
	logic        pend_stopped;
	logic        pend_due;
	logic [31:0] fire_now;

	assign fire_el = drgs_pkg::elapsed(fire_head.mode, fire_head.start,
		item.encoder_now, item.time_now_ms);
	assign pend_el = drgs_pkg::elapsed(pend_head.mode, pend_head.start,
		item.encoder_now, item.time_now_ms);

	assign fire_done = !fire_el.neg && (fire_el.span >= 32'(fire_head.width));
	// keep the gate on when a newer firing lies within this pulse
	assign hold = (last_mark != fire_head.start) &&
		(drgs_pkg::abs_diff(last_mark, fire_head.start) <= 32'(fire_head.width));

	assign pend_stopped = !pend_el.neg && (pend_el.span == '0);
	assign pend_due = !pend_el.neg && (pend_el.span >= 32'(pend_head.delay));
	assign fire_now = (pend_head.mode == drgs_pkg::MODE_ENCODER) ?
		32'(item.encoder_now) : item.time_now_ms;

	assign pend_push = '{mode: item.mode, start: item.start_mark,
		delay: item.delay, width: item.pulse_width};
	assign fire_push = '{mode: pend_head.mode, start: fire_now, width: pend_head.width};

	// an enqueue pushes or drops the request; a tick checks the fired head first, then the pending head
	always_comb begin
		pend_ctl = '0;
		fire_ctl = '0;
		upd = '{gate: gate, mark_we: 1'b0, mark: fire_now};
		result = '0;
		if (item.func == drgs_pkg::FUNC_ENQUEUE) begin
			if (!pend_full)
				pend_ctl.push = 1'b1;
			else
				result.dropped = 1'b1;
		end else begin
			if (!fire_empty && fire_done) begin
				fire_ctl.pop = 1'b1;
				if (!hold) begin
					upd.gate = 1'b0;
					result.released = 1'b1;
				end
			end
			if (!pend_empty) begin
				if (pend_stopped) begin
					pend_ctl.pop = 1'b1;
				end else if (pend_due) begin
					pend_ctl.pop = 1'b1;
					upd.gate = 1'b1;
					upd.mark_we = 1'b1;
					result.fired = 1'b1;
					if (!fire_full || fire_ctl.pop)
						fire_ctl.push = 1'b1;
					else
						result.dropped = 1'b1;
				end
			end
		end
		result.gate_on = upd.gate;
	end

endmodule

`default_nettype wire

[design/delayed_reject_gate_scheduler.sv]
// Channel  | Dir | Payload                                          | Role
// in_ch    | in  | func mode start_mark delay pulse_width enc/ms    | request or tick
// out_ch   | out | gate_on fired released dropped                   | one per item
//
// An item sits in the input register, the decision logic handles the fired head
// and the pending head in one pass, and the result is written to the output
// register. One item per cycle sustained while out_ch is not stalled; the single
// decision pass sets the rate.
// arst_n clears queue counts and heads, the gate level and the last firing mark.
// A stalled output holds its register; the input register holds one more item.
`default_nettype none

module delayed_reject_gate_scheduler (
	input  wire       clk,
	input  wire       arst_n,
	drgs_in_if.sink   in_ch,
	drgs_out_if.source out_ch
);

	drgs_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	drgs_pkg::out_item_t   out_q;
	logic                  out_valid_q;
	logic                  gate_q;
	logic [31:0]           last_mark_q;
	logic                  adv;

	drgs_pkg::pend_entry_t pend_head;
	drgs_pkg::pend_entry_t pend_push;
	drgs_pkg::fire_entry_t fire_head;
	drgs_pkg::fire_entry_t fire_push;
	logic                  pend_empty;
	logic                  pend_full;
	logic                  fire_empty;
	logic                  fire_full;
	drgs_pkg::q_ctl_t      pend_ctl;
	drgs_pkg::q_ctl_t      fire_ctl;
	drgs_pkg::q_ctl_t      pend_ctl_g;
	drgs_pkg::q_ctl_t      fire_ctl_g;
	drgs_pkg::sched_upd_t  upd;
	drgs_pkg::out_item_t   result;

	// the item in stage 1 retires when the output register can take it
	assign adv = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	assign pend_ctl_g = '{push: pend_ctl.push && adv, pop: pend_ctl.pop && adv};
	assign fire_ctl_g = '{push: fire_ctl.push && adv, pop: fire_ctl.pop && adv};

	// capture the input payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_s1 <= '{func: in_ch.func, mode: in_ch.mode,
				start_mark: in_ch.start_mark, delay: in_ch.delay,
				pulse_width: in_ch.pulse_width, encoder_now: in_ch.encoder_now,
				time_now_ms: in_ch.time_now_ms};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// load the result and commit scheduler state
	always_ff @(posedge clk) begin
		if (adv)
			out_q <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			gate_q <= 1'b0;
			last_mark_q <= '0;
		end else begin
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			if (adv) begin
				gate_q <= upd.gate;
				if (upd.mark_we)
					last_mark_q <= upd.mark;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.gate_on = out_q.gate_on;
	assign out_ch.fired = out_q.fired;
	assign out_ch.released = out_q.released;
	assign out_ch.dropped = out_q.dropped;

	drgs_pend_queue u_pend (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (pend_ctl_g),
		.push_entry (pend_push),
		.head_entry (pend_head),
		.empty      (pend_empty),
		.full       (pend_full)
	);

	drgs_fire_queue u_fire (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fire_ctl_g),
		.push_entry (fire_push),
		.head_entry (fire_head),
		.empty      (fire_empty),
		.full       (fire_full)
	);

	drgs_decide u_decide (
		.item       (item_s1),
		.pend_head  (pend_head),
		.pend_empty (pend_empty),
		.pend_full  (pend_full),
		.fire_head  (fire_head),
		.fire_empty (fire_empty),
		.fire_full  (fire_full),
		.last_mark  (last_mark_q),
		.gate       (gate_q),
		.pend_ctl   (pend_ctl),
		.fire_ctl   (fire_ctl),
		.pend_push  (pend_push),
		.fire_push  (fire_push),
		.upd        (upd),
		.result     (result)
	);

endmodule

`default_nettype wire

[design/drgs_checker.sv]
`default_nettype none
`include "delayed_reject_gate_scheduler_defines.svh"

module drgs_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire gate_on,
	input wire fired,
	input wire released,
	input wire dropped
);

	// a firing always leaves the gate on
	`DRGS_ASSERT_NOW(a_fired_gate_on, out_valid && fired, gate_on, "fired without gate on")

	// a release with no new firing leaves the gate off
	`DRGS_ASSERT_NOW(a_release_gate_off, out_valid && released && !fired, !gate_on, "released but gate on")

	// input backs up only behind a stalled result
	`DRGS_ASSERT_NOW(a_ready_low_stall, !in_ready, out_valid && !out_ready, "input stalled without output stall")

	// a stalled result holds
	`DRGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({gate_on, fired, released, dropped}), "stalled result changed")

endmodule

bind delayed_reject_gate_scheduler drgs_checker u_drgs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.gate_on   (out_ch.gate_on),
	.fired     (out_ch.fired),
	.released  (out_ch.released),
	.dropped   (out_ch.dropped)
);

`default_nettype wire
